// ===== design/plcm_pkg.sv =====
package plcm_pkg;

	localparam int MAX_POINTS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int LVL_W      = FRAC_BITS + 1;
	localparam int DATA_W     = 32;
	localparam int DIV_W      = 32;
	localparam int PROD_W     = 2 * LVL_W;
	localparam int IN_TDATA_W = ((IDX_W + 4 * LVL_W + DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 24;

	localparam logic [LVL_W-1:0] ONE_Q = LVL_W'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		CFG_DATA_MIN    = 2'd0,
		CFG_DATA_MAX    = 2'd1,
		CFG_POINT_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MAP  = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_NCHK,
		ST_NDIV,
		ST_SRCH,
		ST_SCMP,
		ST_RDL,
		ST_RDR,
		ST_FRAC,
		ST_FDIV,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [LVL_W-1:0] blue;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] red;
		logic [LVL_W-1:0] pos;
	} point_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		point_t           point;
	} tbl_wr_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [FRAC_BITS-1:0] quot;
	} div_rsp_t;

	function automatic logic [LVL_W-1:0] sat_one(input logic [LVL_W-1:0] x);
		return (x > ONE_Q) ? ONE_Q : x;
	endfunction

endpackage

// ===== design/plcm_div.sv =====
module plcm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  plcm_pkg::div_req_t req,
	output plcm_pkg::div_rsp_t rsp
);
	import plcm_pkg::*;

	localparam int STEP_W = $clog2(FRAC_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [DIV_W:0]       rem_sh;
	logic [DIV_W:0]       rem_diff;
	logic                 take;

	// remainder stays below the divisor, so the shifted value fits one extra bit
	assign rem_sh   = {rem_q, 1'b0};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign take     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= take ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== design/plcm_table.sv =====
module plcm_table (
	input  logic                          clk,
	input  plcm_pkg::tbl_wr_t             wr,
	input  logic [plcm_pkg::IDX_W-1:0]    rd_addr,
	output plcm_pkg::point_t              rd_data
);
	import plcm_pkg::*;

	point_t mem_q [MAX_POINTS];
	point_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.idx] <= wr.point;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== design/piecewise_linear_color_map_unit.sv =====
// Piecewise linear color map: turns a signed sample into an RGB byte triple.
// Input stream: tuser is the command (load a control point or map a sample),
// tdata carries the point index, position, red, green, blue and the sample.
// A load writes one table entry at the accept edge and produces no result;
// the block is ready again in the next cycle.
// A map takes one item at a time: normalization by a 16-step shift-subtract
// divider, a binary search of up to four steps (states SRCH and SCMP each,
// one table read port), two table reads, a second 16-step division for the
// interval fraction, then states MUL0 to MUL3 per channel on one 17x17
// multiplier; each division is skipped where its result clamps to 0 or one.
// Both divisions use the shared divider; ready stays low until idle again.
// The result sits in an output register; the next item is taken while it
// waits, and a finished map holds in its last step until that register is
// free, so a stalled receiver stalls the block only then.
// Configuration (data_min, data_max, point_count) is for the user to write
// via the cfg port only while idle; not enforced. Reset clears control state
// and registers to 0, 65535 and 2; the point table is undefined until loaded.
module piecewise_linear_color_map_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// point_index, point_position, point_red, point_green, point_blue, sample
	input  logic [plcm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// cmd
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// red, green, blue
	output logic [plcm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [plcm_pkg::DATA_W-1:0]       cfg_data
);
	import plcm_pkg::*;

	localparam int POS_LSB = IDX_W;
	localparam int RED_LSB = POS_LSB + LVL_W;
	localparam int GRN_LSB = RED_LSB + LVL_W;
	localparam int BLU_LSB = GRN_LSB + LVL_W;
	localparam int SMP_LSB = BLU_LSB + LVL_W;
	localparam int ACC_W   = PROD_W;
	localparam int SCL_W   = ACC_W + 8;

	// configuration
	logic signed [DATA_W-1:0] data_min_q;
	logic signed [DATA_W-1:0] data_max_q;
	logic [CNT_W-1:0]         point_count_q;

	// sequencer
	state_t state_q, state_d;

	logic signed [DATA_W-1:0] sample_q;
	logic signed [DATA_W:0]   range_q;
	logic signed [DATA_W:0]   diff_q;
	logic [LVL_W-1:0]         v_q;
	logic [LVL_W-1:0]         frac_q;
	logic [IDX_W-1:0]         lo_q, hi_q;
	logic [IDX_W-1:0]         right_q;
	point_t                   pl_q, pr_q;
	logic [1:0]               chan_q;
	logic [ACC_W-1:0]         acc_q;
	logic [PROD_W-1:0]        prod_q;
	logic [7:0]               rgb_q [3];
	logic [OUT_TDATA_W-1:0]   out_q;
	logic                     out_valid_q;

	// shared units
	tbl_wr_t          tbl_wr;
	logic [IDX_W-1:0] rd_addr;
	point_t           rd_data;
	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [LVL_W-1:0] mul_a, mul_b;

	// combinational helpers
	logic             s_accept;
	cmd_t             s_cmd;
	logic [CNT_W-1:0] n_clamped;
	logic [CNT_W-1:0] n_m1;
	logic [IDX_W:0]   mid_sum;
	logic [IDX_W-1:0] mid;
	logic             norm_zero;
	logic             norm_one;
	logic             frac_zero;
	logic             frac_one;
	logic [SCL_W-1:0] scaled;
	logic [7:0]       chan_byte;
	logic             out_free;

	assign s_cmd    = cmd_t'(s_axis_tuser);
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		if (point_count_q < CNT_W'(2)) begin
			n_clamped = CNT_W'(2);
		end else if (point_count_q > CNT_W'(MAX_POINTS)) begin
			n_clamped = CNT_W'(MAX_POINTS);
		end else begin
			n_clamped = point_count_q;
		end
	end
	assign n_m1 = n_clamped - CNT_W'(1);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];

	assign norm_zero = range_q[DATA_W] || (range_q == '0) || diff_q[DATA_W] || (diff_q == '0);
	assign norm_one  = (diff_q >= range_q);

	assign frac_zero = (pr_q.pos <= pl_q.pos) || (v_q <= pl_q.pos);
	assign frac_one  = (v_q >= pr_q.pos);

	// times 255 as a shift and subtract, then drop the two fraction fields
	assign scaled    = {acc_q, 8'd0} - {8'd0, acc_q};
	assign chan_byte = scaled[2*FRAC_BITS +: 8];

	// table write on a load
	always_comb begin
		tbl_wr.en          = s_accept && (s_cmd == CMD_LOAD);
		tbl_wr.idx         = s_axis_tdata[IDX_W-1:0];
		tbl_wr.point.pos   = sat_one(s_axis_tdata[POS_LSB +: LVL_W]);
		tbl_wr.point.red   = sat_one(s_axis_tdata[RED_LSB +: LVL_W]);
		tbl_wr.point.green = sat_one(s_axis_tdata[GRN_LSB +: LVL_W]);
		tbl_wr.point.blue  = sat_one(s_axis_tdata[BLU_LSB +: LVL_W]);
	end

	plcm_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	plcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_min_q    <= '0;
			data_max_q    <= DATA_W'(65535);
			point_count_q <= CNT_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_DATA_MIN:    data_min_q    <= cfg_data;
				CFG_DATA_MAX:    data_max_q    <= cfg_data;
				CFG_POINT_COUNT: point_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = (state_q == ST_IDLE);
		rd_addr       = mid;
		div_req.start = 1'b0;
		div_req.num   = diff_q[DIV_W-1:0];
		div_req.den   = range_q[DIV_W-1:0];
		mul_a         = pl_q.red;
		mul_b         = ONE_Q - frac_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept && (s_cmd == CMD_MAP)) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: state_d = ST_NCHK;
			ST_NCHK: begin
				if (norm_zero || norm_one) begin
					state_d = ST_SRCH;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_NDIV;
				end
			end
			ST_NDIV: begin
				if (div_rsp.done) begin
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					state_d = ST_SCMP;
				end else begin
					rd_addr = (lo_q == '0) ? '0 : lo_q - IDX_W'(1);
					state_d = ST_RDL;
				end
			end
			ST_SCMP: state_d = ST_SRCH;
			ST_RDL: begin
				rd_addr = right_q;
				state_d = ST_RDR;
			end
			ST_RDR: state_d = ST_FRAC;
			ST_FRAC: begin
				div_req.num = DIV_W'(v_q - pl_q.pos);
				div_req.den = DIV_W'(pr_q.pos - pl_q.pos);
				if (frac_zero || frac_one) begin
					state_d = ST_MUL0;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_FDIV;
				end
			end
			ST_FDIV: begin
				if (div_rsp.done) begin
					state_d = ST_MUL0;
				end
			end
			ST_MUL0: begin
				unique case (chan_q)
					2'd0:    mul_a = pl_q.red;
					2'd1:    mul_a = pl_q.green;
					default: mul_a = pl_q.blue;
				endcase
				mul_b   = ONE_Q - frac_q;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				unique case (chan_q)
					2'd0:    mul_a = pr_q.red;
					2'd1:    mul_a = pr_q.green;
					default: mul_a = pr_q.blue;
				endcase
				mul_b   = frac_q;
				state_d = ST_MUL2;
			end
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: begin
				state_d = (chan_q == 2'd2) ? ST_DONE : ST_MUL0;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sample_q <= s_axis_tdata[SMP_LSB +: DATA_W];
			end
			ST_NORM: begin
				range_q <= {data_max_q[DATA_W-1], data_max_q} - {data_min_q[DATA_W-1], data_min_q};
				diff_q  <= {sample_q[DATA_W-1], sample_q} - {data_min_q[DATA_W-1], data_min_q};
				lo_q    <= '0;
				hi_q    <= n_m1[IDX_W-1:0];
			end
			ST_NCHK: begin
				if (norm_zero) begin
					v_q <= '0;
				end else if (norm_one) begin
					v_q <= ONE_Q;
				end
			end
			ST_NDIV: begin
				if (div_rsp.done) begin
					v_q <= {1'b0, div_rsp.quot};
				end
			end
			ST_SRCH: begin
				if (!(lo_q < hi_q)) begin
					right_q <= (lo_q == '0) ? IDX_W'(1) : lo_q;
				end
			end
			ST_SCMP: begin
				if (v_q > rd_data.pos) begin
					lo_q <= mid + IDX_W'(1);
				end else begin
					hi_q <= mid;
				end
			end
			ST_RDL: pl_q <= rd_data;
			ST_RDR: pr_q <= rd_data;
			ST_FRAC: begin
				chan_q <= 2'd0;
				if (frac_zero) begin
					frac_q <= '0;
				end else if (frac_one) begin
					frac_q <= ONE_Q;
				end
			end
			ST_FDIV: begin
				if (div_rsp.done) begin
					frac_q <= {1'b0, div_rsp.quot};
				end
			end
			ST_MUL0: ;
			ST_MUL1: acc_q <= prod_q;
			ST_MUL2: acc_q <= acc_q + prod_q;
			ST_MUL3: begin
				rgb_q[chan_q] <= chan_byte;
				chan_q        <= chan_q + 2'd1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q <= {rgb_q[2], rgb_q[1], rgb_q[0]};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_NDIV || state_q == ST_FDIV))
		else $error("divider finished outside a division wait");

	a_map_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_axis_tuser) |=> !s_axis_tready)
		else $error("ready stayed high after a map request");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished map");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCMP) |-> (lo_q < hi_q))
		else $error("search compare with empty interval");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import plcm_pkg::*;

	localparam longint UNITY          = 64'd1 << FRAC_BITS;
	localparam longint S32_MIN        = -64'sd2147483648;
	localparam longint S32_MAX        = 64'sd2147483647;
	localparam logic [1:0] CFG_SPARE  = 2'd3;
	localparam int     SETTLE_CYCLES  = 64;
	localparam int     HOLD_OFF_CYCLES = 600;
	localparam int     PHASES         = 10;
	localparam int     PHASE_ITEMS    = 75;

	typedef struct packed {
		logic [DATA_W-1:0] sample;
		logic [LVL_W-1:0]  blue;
		logic [LVL_W-1:0]  green;
		logic [LVL_W-1:0]  red;
		logic [LVL_W-1:0]  pos;
		logic [IDX_W-1:0]  idx;
	} request_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	class rgb_scoreboard;
		longint           range_lo;
		longint           range_hi;
		int unsigned      points;
		logic [LVL_W-1:0] position [MAX_POINTS];
		logic [LVL_W-1:0] level [MAX_POINTS][3];
		rgb_t             pending [$];
		int               failures;

		function new();
			range_lo = 0;
			range_hi = 65535;
			points   = 2;
			failures = 0;
		endfunction

		function void write_register(logic [1:0] idx, logic [DATA_W-1:0] value);
			case (idx)
				CFG_DATA_MIN:    range_lo = longint'(signed'(value));
				CFG_DATA_MAX:    range_hi = longint'(signed'(value));
				CFG_POINT_COUNT: points = 32'(value[4:0]);
				default: ;
			endcase
		endfunction

		function logic [LVL_W-1:0] limit_level(logic [LVL_W-1:0] x);
			return (longint'(x) > UNITY) ? LVL_W'(UNITY) : x;
		endfunction

		// floor(num * one / den), num and den positive
		function longint unit_ratio(longint num, longint den);
			return (num <<< FRAC_BITS) / den;
		endfunction

		function rgb_t map_sample(logic [DATA_W-1:0] sample);
			longint     span, diff, v, pl, pr, frac, mix;
			int         n, lo, hi, mid, left, right;
			logic [7:0] chan [3];
			rgb_t       rgb;
			n = (points < 2) ? 2 : (points > MAX_POINTS) ? MAX_POINTS : int'(points);
			span = range_hi - range_lo;
			diff = longint'(signed'(sample)) - range_lo;
			if (span <= 0 || diff <= 0)
				v = 0;
			else if (diff >= span)
				v = UNITY;
			else
				v = unit_ratio(diff, span);
			lo = 0;
			hi = n - 1;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (v > longint'(position[mid]))
					lo = mid + 1;
				else
					hi = mid;
			end
			// search stopping at the bottom entry uses the first pair
			right = (lo == 0) ? 1 : lo;
			left  = right - 1;
			pl = longint'(position[left]);
			pr = longint'(position[right]);
			if (pr <= pl || v <= pl)
				frac = 0;
			else if (v >= pr)
				frac = UNITY;
			else
				frac = unit_ratio(v - pl, pr - pl);
			for (int c = 0; c < 3; c++) begin
				mix = longint'(level[left][c]) * (UNITY - frac)
				    + longint'(level[right][c]) * frac;
				chan[c] = 8'((mix * 255) >>> (2 * FRAC_BITS));
			end
			rgb.red   = chan[0];
			rgb.green = chan[1];
			rgb.blue  = chan[2];
			return rgb;
		endfunction

		function void note_request(cmd_t cmd, request_t req);
			if (cmd == CMD_LOAD) begin
				position[req.idx] = limit_level(req.pos);
				level[req.idx][0] = limit_level(req.red);
				level[req.idx][1] = limit_level(req.green);
				level[req.idx][2] = limit_level(req.blue);
			end else begin
				pending = {pending, map_sample(req.sample)};
			end
		endfunction

		function void check_result(rgb_t got);
			rgb_t want;
			if (pending.size() == 0) begin
				$error("color result %h with no map request pending", got);
				failures++;
				return;
			end
			want = pending.pop_front();
			if (got.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				failures++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				failures++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				failures++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we;
	logic [1:0]             cfg_index;
	logic [DATA_W-1:0]      cfg_data;

	rgb_scoreboard sb;
	bit            sender_idles;
	bit            receiver_stalls;
	bit            hold_off_armed;
	bit            hold_off_done;

	piecewise_linear_color_map_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_request(cmd_t'(s_axis_tuser), request_t'(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(rgb_t'(m_axis_tdata));
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		hold_off_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_armed && !hold_off_done) begin
				hold_off_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			m_axis_tready <= !(receiver_stalls && $urandom_range(0, 99) < 22);
		end
	end

	function automatic logic [LVL_W-1:0] random_level();
		return LVL_W'($urandom_range(0, 65536));
	endfunction

	function automatic request_t point_request(logic [IDX_W-1:0] idx,
		logic [LVL_W-1:0] pos, logic [LVL_W-1:0] red, logic [LVL_W-1:0] green,
		logic [LVL_W-1:0] blue);
		request_t req;
		req.sample = $urandom;
		req.idx    = idx;
		req.pos    = pos;
		req.red    = red;
		req.green  = green;
		req.blue   = blue;
		return req;
	endfunction

	function automatic request_t map_request(logic [DATA_W-1:0] sample);
		request_t req;
		req = point_request(IDX_W'($urandom), LVL_W'($urandom), LVL_W'($urandom),
			LVL_W'($urandom), LVL_W'($urandom));
		req.sample = sample;
		return req;
	endfunction

	// mostly near the configured range, some at or beside the bounds, some anywhere
	function automatic logic [DATA_W-1:0] pick_sample();
		longint          span, val;
		longint unsigned r;
		int              choice;
		choice = $urandom_range(0, 9);
		span   = sb.range_hi - sb.range_lo;
		r      = {$urandom, $urandom};
		if (choice == 0 || span <= 0)
			return $urandom;
		if (choice == 1)
			val = ($urandom_range(0, 1) ? sb.range_lo : sb.range_hi)
			    + longint'($urandom_range(0, 2)) - 1;
		else
			val = sb.range_lo - span / 8
			    + longint'(r % longint'(span + span / 4 + 1));
		if (val < S32_MIN)
			val = S32_MIN;
		if (val > S32_MAX)
			val = S32_MAX;
		return val[DATA_W-1:0];
	endfunction

	task automatic send_request(input cmd_t cmd, input request_t req);
		while (sender_idles && $urandom_range(0, 99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= req;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_map(input logic [DATA_W-1:0] sample);
		send_request(CMD_MAP, map_request(sample));
	endtask

	// drop valid, let every pending color come back, then let the block settle
	task automatic wait_for_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.write_register(idx, value);
		@(negedge clk);
	endtask

	task automatic set_registers(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
		input logic [DATA_W-1:0] count);
		write_register(CFG_DATA_MIN, lo);
		write_register(CFG_DATA_MAX, hi);
		write_register(CFG_POINT_COUNT, count);
		write_register(CFG_SPARE, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic random_registers();
		logic [DATA_W-1:0] lo, hi, count;
		int                mode;
		mode = $urandom_range(0, 9);
		lo   = 32'($urandom_range(0, 4000)) - 32'd2000;
		hi   = lo + 32'($urandom_range(1, 300000));
		case (mode)
			4: begin
				lo = 32'h8000_0000;
				hi = 32'h7FFF_FFFF;
			end
			5, 6: begin
				lo = $urandom;
				hi = $urandom;
			end
			7: hi = lo;
			8: hi = lo - 32'($urandom_range(1, 5000));
			9: hi = lo + 32'd1;
			default: ;
		endcase
		count = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 31))
		                                    : 32'($urandom_range(2, 16));
		set_registers(lo, hi, count);
	endtask

	// ascending positions ending at one, random levels; returns items sent
	task automatic reload_table(output int sent);
		int               n, stride;
		logic [LVL_W-1:0] pos;
		n = (sb.points < 2) ? 2 : (sb.points > MAX_POINTS) ? MAX_POINTS : int'(sb.points);
		stride = 2 * 65536 / (n - 1);
		pos = ($urandom_range(0, 3) == 0) ? LVL_W'($urandom_range(1, 8000)) : '0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (i >= n - 1)
				pos = LVL_W'(UNITY);
			send_request(CMD_LOAD, point_request(IDX_W'(i), pos, random_level(),
				random_level(), random_level()));
			pos = (longint'(pos) + stride > UNITY) ? LVL_W'(UNITY)
			                                       : LVL_W'(pos + $urandom_range(0, stride));
		end
		sent = MAX_POINTS;
	endtask

	initial begin
		int budget, sent;
		sb              = new();
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
		hold_off_armed  = 1'b0;
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full table: equal positions at entries 2 and 3, last position above one
		for (int i = 0; i < MAX_POINTS; i++) begin
			send_request(CMD_LOAD, point_request(IDX_W'(i),
				(i == 15) ? LVL_W'(17'h1FFFF) : LVL_W'(((i == 3) ? 2 : i) * 4369),
				(i % 2 == 1) ? LVL_W'(17'h1FFFF) : LVL_W'(0),
				LVL_W'(i * 4369), LVL_W'(65536 - i * 4369)));
		end
		// registers as they come out of reset
		send_map(32'd0);
		send_map(32'd65535);
		send_map(32'hFFFF_FFFB);

		wait_for_idle();
		set_registers(32'd0, 32'd65535, 32'd16);
		send_map(32'd8738);
		send_map(32'd8739);
		send_map(32'd30000);
		send_map(32'd65536);

		wait_for_idle();
		set_registers(32'h8000_0000, 32'h7FFF_FFFF, 32'd31);
		send_map(32'h8000_0000);
		send_map(32'h7FFF_FFFF);

		wait_for_idle();
		set_registers(32'd100, 32'd100, 32'd0);
		send_map(32'd100);

		wait_for_idle();
		set_registers(32'd200, 32'hFFFF_FF38, 32'd1);
		send_map(32'd0);

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_for_idle();
			random_registers();
			sender_idles    = (phase != 5);
			receiver_stalls = (phase != 5);
			budget          = PHASE_ITEMS;
			if (phase == 3) begin
				// keep offering maps while the result side holds off
				sender_idles   = 1'b0;
				hold_off_armed = 1'b1;
				repeat (24) send_map(pick_sample());
				budget -= 24;
				sender_idles = 1'b1;
			end
			if (phase == 0 || $urandom_range(0, 1) == 1) begin
				reload_table(sent);
				budget -= sent;
			end
			while (budget > 0) begin
				if ($urandom_range(0, 99) < 15)
					send_request(CMD_LOAD, point_request(IDX_W'($urandom),
						LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom),
						LVL_W'($urandom)));
				else
					send_map(pick_sample());
				budget--;
			end
		end

		wait_for_idle();
		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/plcm_pkg.sv
design/plcm_div.sv
design/plcm_table.sv
design/piecewise_linear_color_map_unit.sv
sim/tb_top.sv
